>>> design/coordinate_liftover_block_table_defines.svh
// Assertion macros shared by the liftover block table design files.
`ifndef COORDINATE_LIFTOVER_BLOCK_TABLE_DEFINES_SVH
`define COORDINATE_LIFTOVER_BLOCK_TABLE_DEFINES_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside of reset.
`define CLBT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("clbt assertion failed");

// Checks a property on every rising clock edge, reset included.
`define CLBT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("clbt assertion failed");

`else

`define CLBT_ASSERT(lbl, prop)
`define CLBT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> design/clbt_pkg.sv
// Types and constants of the liftover block table.
`timescale 1ns / 1ps

package clbt_pkg;

   localparam int POS_W              = 31;
   localparam int MAX_BLOCKS_DEFAULT = 4096;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [POS_W-1:0] block_size;
      logic [POS_W-1:0] target_gap;
      logic [POS_W-1:0] query_gap;
      logic [POS_W-1:0] location;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] new_location;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] target_start;
      logic [POS_W-1:0] block_length;
   } pair_type;

endpackage

>>> design/coordinate_liftover_block_table.sv
// Liftover block table: chain storage, binary search and coordinate translation.
`timescale 1ns / 1ps
`include "coordinate_liftover_block_table_defines.svh"

// The block keeps one alignment chain as a table of ungapped blocks and turns
// source coordinates into target coordinates. A transfer happens at a rising
// edge with start high and busy low. Every transfer gives exactly one result,
// shown on rsp_item for a single cycle with rsp_valid high; the receiver cannot
// hold it off, so it must take each result in that cycle. A clear (or the unused
// mode) answers in the cycle after its transfer and leaves busy low. An append
// keeps busy high in its append state and answers right after. A query walks a
// binary search through the source-start memory, one probe per cycle because
// that memory has a single registered read port; it keeps busy high through
// its probes and, when a block starts at or before the location, a finish
// state that reads the target start and length, and its result follows right
// after busy falls. An empty table answers unmapped at once.
// There is no clearing pass after reset: entries at or above the block count
// never reach a result, so the tables need no initialization.
module coordinate_liftover_block_table #(
   parameter int MAX_BLOCKS = clbt_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  clbt_pkg::req_type req_item,
   output logic              rsp_valid,
   output clbt_pkg::rsp_type rsp_item
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int PW = clbt_pkg::POS_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_APPEND = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // Source starts are probed by the search; target start and length are only
   // needed for the block that the search lands on, so they share a second memory.
   logic [PW-1:0]      src_mem  [MAX_BLOCKS];
   clbt_pkg::pair_type pair_mem [MAX_BLOCKS];

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      src_pos_ff, src_pos_in;
   logic [PW-1:0]      tgt_pos_ff, tgt_pos_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [IW-1:0]      mid_ff, mid_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      found_idx_ff, found_idx_in;
   logic [PW-1:0]      offset_ff, offset_in;
   clbt_pkg::req_type  req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   clbt_pkg::rsp_type  rsp_ff, rsp_in;

   logic [PW-1:0]      src_rd_ff;
   clbt_pkg::pair_type pair_rd_ff;
   logic [IW-1:0]      src_rd_addr;
   logic [IW-1:0]      pair_rd_addr;
   logic               mem_we;

   // Search step signals.
   logic               go_right;
   logic [CW-1:0]      lo_next;
   logic [CW-1:0]      hi_next;
   logic [CW:0]        mid_sum;
   logic [IW-1:0]      mid_next;
   logic               found_next;
   logic [IW-1:0]      found_idx_next;

   // Append checks.
   logic [PW+1:0]      next_src;
   logic [PW+1:0]      next_tgt;
   logic               table_full;
   logic               pos_overflow;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The probe at mid_ff decides which half survives. A start at or before the
   // location moves the lower bound past mid and makes mid the best candidate.
   always_comb begin
      go_right       = !(src_rd_ff > req_ff.location);
      lo_next        = go_right ? (CW'(mid_ff) + CW'(1)) : lo_ff;
      hi_next        = go_right ? hi_ff : CW'(mid_ff);
      mid_sum        = (CW+1)'(lo_next) + (CW+1)'(hi_next);
      mid_next       = mid_sum[IW:1];
      found_next     = found_ff | go_right;
      found_idx_next = go_right ? mid_ff : found_idx_ff;
   end

   // Both advanced positions are formed with two spare bits so that any carry
   // past the 31-bit coordinate range shows up as an overflow.
   always_comb begin
      next_src     = (PW+2)'(src_pos_ff) + (PW+2)'(req_ff.block_size)
                   + (PW+2)'(req_ff.query_gap);
      next_tgt     = (PW+2)'(tgt_pos_ff) + (PW+2)'(req_ff.block_size)
                   + (PW+2)'(req_ff.target_gap);
      table_full   = (count_ff >= MAX_CNT);
      pos_overflow = (next_src[PW+1:PW] != 2'd0) || (next_tgt[PW+1:PW] != 2'd0);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      src_pos_in   = src_pos_ff;
      tgt_pos_in   = tgt_pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      offset_in    = offset_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      src_rd_addr  = mid_ff;
      pair_rd_addr = found_idx_ff;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               case (req_item.mode)
                  clbt_pkg::MODE_CLEAR: begin
                     count_in     = '0;
                     src_pos_in   = '0;
                     tgt_pos_in   = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: clbt_pkg::STATUS_OK, new_location: '0};
                  end
                  clbt_pkg::MODE_APPEND: begin
                     state_in = S_APPEND;
                  end
                  clbt_pkg::MODE_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: clbt_pkg::STATUS_UNMAPPED, new_location: '0};
                     end else begin
                        // First probe sits at the middle of [0, count).
                        lo_in       = '0;
                        hi_in       = count_ff;
                        mid_in      = IW'(count_ff >> 1);
                        src_rd_addr = IW'(count_ff >> 1);
                        found_in    = 1'b0;
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: clbt_pkg::STATUS_OK, new_location: '0};
                  end
               endcase
            end
         end

         S_APPEND: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (table_full || pos_overflow) begin
               rsp_in = '{status: clbt_pkg::STATUS_FULL, new_location: '0};
            end else begin
               mem_we     = 1'b1;
               count_in   = count_ff + CW'(1);
               src_pos_in = next_src[PW-1:0];
               tgt_pos_in = next_tgt[PW-1:0];
               rsp_in     = '{status: clbt_pkg::STATUS_OK, new_location: '0};
            end
         end

         S_SEARCH: begin
            lo_in        = lo_next;
            hi_in        = hi_next;
            found_in     = found_next;
            found_idx_in = found_idx_next;
            if (go_right) begin
               offset_in = req_ff.location - src_rd_ff;
            end
            if (lo_next < hi_next) begin
               mid_in      = mid_next;
               src_rd_addr = mid_next;
            end else if (found_next) begin
               // Fetch target start and length of the landing block.
               pair_rd_addr = found_idx_next;
               state_in     = S_FINISH;
            end else begin
               // Location lies before the first block.
               rsp_valid_in = 1'b1;
               rsp_in = '{status: clbt_pkg::STATUS_UNMAPPED, new_location: '0};
               state_in = S_IDLE;
            end
         end

         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (offset_ff >= pair_rd_ff.block_length) begin
               rsp_in = '{status: clbt_pkg::STATUS_UNMAPPED, new_location: '0};
            end else begin
               rsp_in = '{status: clbt_pkg::STATUS_OK,
                          new_location: pair_rd_ff.target_start + offset_ff};
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Writes happen only in the append state and read data is used only in the
   // search and finish states, so the sequencer keeps a write and a used read apart.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         src_mem[count_ff[IW-1:0]]  <= src_pos_ff;
         pair_mem[count_ff[IW-1:0]] <= '{target_start: tgt_pos_ff,
                                         block_length: req_ff.block_size};
      end
      src_rd_ff  <= src_mem[src_rd_addr];
      pair_rd_ff <= pair_mem[pair_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         src_pos_ff   <= '0;
         tgt_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         src_pos_ff   <= src_pos_in;
         tgt_pos_ff   <= tgt_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      found_idx_ff <= found_idx_in;
      offset_ff    <= offset_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   `CLBT_ASSERT(a_count_in_range, count_ff <= MAX_CNT)
   `CLBT_ASSERT(a_search_bounds, (state_ff == S_SEARCH) |-> ((lo_ff < hi_ff) && (hi_ff <= count_ff)))
   `CLBT_ASSERT(a_unmapped_is_zero, (rsp_valid_ff && (rsp_ff.status != clbt_pkg::STATUS_OK)) |-> (rsp_ff.new_location == '0))
   `CLBT_ASSERT(a_transfer_progress, (start && !busy) |=> (busy || rsp_valid))
   `CLBT_ASSERT(a_finish_has_result, (state_ff == S_FINISH) |=> (rsp_valid && (state_ff == S_IDLE)))
   `CLBT_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_valid && !busy))

endmodule

>>> tb/coordinate_liftover_block_table_checker.sv
// Checker for the liftover block table: predicts each result and compares it.
`timescale 1ns / 1ps

module coordinate_liftover_block_table_checker #(
   parameter int MAX_BLOCKS = clbt_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  clbt_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  clbt_pkg::rsp_type rsp_item,
   output int                outstanding,
   output int                mismatches
);
   import clbt_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX    = '1;
   localparam int               REPORT_MAX = 10;

   logic [POS_W-1:0] src_start_mem [MAX_BLOCKS];
   logic [POS_W-1:0] tgt_start_mem [MAX_BLOCKS];
   logic [POS_W-1:0] len_mem       [MAX_BLOCKS];
   int               stored_blocks;
   logic [POS_W-1:0] src_cursor;
   logic [POS_W-1:0] tgt_cursor;
   rsp_type          expected_q [$];

   // Applies one request to the chain copy held here and returns the answer.
   function automatic rsp_type translate(input req_type r);
      rsp_type         reply;
      longint unsigned next_src;
      longint unsigned next_tgt;
      longint unsigned block_end;
      int              hit;
      reply = '0;
      reply.status = STATUS_OK;
      case (r.mode)
         MODE_CLEAR: begin
            stored_blocks = 0;
            src_cursor = '0;
            tgt_cursor = '0;
         end
         MODE_APPEND: begin
            next_src = 64'(src_cursor) + 64'(r.block_size) + 64'(r.query_gap);
            next_tgt = 64'(tgt_cursor) + 64'(r.block_size) + 64'(r.target_gap);
            if (stored_blocks >= MAX_BLOCKS || next_src > 64'(POS_MAX) ||
                next_tgt > 64'(POS_MAX)) begin
               reply.status = STATUS_FULL;
            end else begin
               src_start_mem[stored_blocks] = src_cursor;
               tgt_start_mem[stored_blocks] = tgt_cursor;
               len_mem[stored_blocks] = r.block_size;
               stored_blocks++;
               src_cursor = next_src[POS_W-1:0];
               tgt_cursor = next_tgt[POS_W-1:0];
            end
         end
         MODE_QUERY: begin
            // Starts never decrease, so the last block at or before the
            // location is simply the last one that passes the test.
            hit = -1;
            for (int i = 0; i < stored_blocks; i++) begin
               if (src_start_mem[i] <= r.location) hit = i;
            end
            if (hit < 0) begin
               reply.status = STATUS_UNMAPPED;
            end else begin
               block_end = 64'(src_start_mem[hit]) + 64'(len_mem[hit]);
               if (64'(r.location) >= block_end) begin
                  reply.status = STATUS_UNMAPPED;
               end else begin
                  reply.new_location = tgt_start_mem[hit] + (r.location - src_start_mem[hit]);
               end
            end
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored_blocks = 0;
         src_cursor = '0;
         tgt_cursor = '0;
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("%0t: result with nothing expected: status %0d location %0d",
                           $realtime, rsp_item.status, rsp_item.new_location);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.new_location !== want.new_location) begin
                  if (mismatches < REPORT_MAX)
                     $display("%0t: mismatch: expected status %0d location %0d, got %0d %0d",
                              $realtime, want.status, want.new_location,
                              rsp_item.status, rsp_item.new_location);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) expected_q = {expected_q, translate(req_item)};
      end
      outstanding = expected_q.size();
   end

endmodule

>>> tb/coordinate_liftover_block_table_tb.sv
// Testbench top for the liftover block table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module coordinate_liftover_block_table_tb;
   import clbt_pkg::*;

   // A small table keeps the full-table case reachable by ordinary chains
   // while the search still takes several probes.
   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 2000;
   // Cycles with neither a request transfer nor a result before the run is
   // declared hung. The slowest legal gap is a short query plus a long idle
   // streak on the sender side, far below this.
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   // The sender adds no random idle cycles while the item count lies in this window.
   localparam int BURST_FIRST  = 800;
   localparam int BURST_LAST   = 1300;

   localparam logic [POS_W-1:0] POS_MAX     = '1;
   localparam logic [1:0]       MODE_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   int outstanding;
   int mismatches;
   int quiet_cycles;
   int items_sent;
   int chain_blocks;

   // Stimulus-side sketch of the chain being built. It only steers query
   // locations toward block edges; it plays no part in checking.
   longint unsigned  chain_cursor;
   logic [POS_W-1:0] chain_starts [$];
   logic [POS_W-1:0] chain_lengths [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   coordinate_liftover_block_table #(
      .MAX_BLOCKS(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   coordinate_liftover_block_table_checker #(
      .MAX_BLOCKS(TABLE_DEPTH)
   ) liftover_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .outstanding(outstanding),
      .mismatches (mismatches)
   );

   function automatic logic [POS_W-1:0] rand_pos();
      return POS_W'($urandom);
   endfunction

   // Block sizes and gaps: mostly short so chains grow long, with zeros,
   // mid-range values and a few huge ones that push a position past its range.
   function automatic logic [POS_W-1:0] rand_span();
      case ($urandom_range(19))
         0, 1:                    return '0;
         2, 3, 4, 5, 6, 7, 8, 9:  return POS_W'($urandom_range(1, 4000));
         10, 11, 12, 13:          return POS_W'($urandom_range(0, 65535));
         14, 15, 16:              return POS_W'($urandom_range(0, 1 << 24));
         17, 18:                  return rand_pos();
         default:                 return POS_MAX - POS_W'($urandom_range(0, 3));
      endcase
   endfunction

   // Every field carries random content, so the fields that a mode ignores
   // still see every bit in both states.
   function automatic req_type rand_request();
      req_type r;
      r.mode       = 2'($urandom);
      r.block_size = rand_pos();
      r.target_gap = rand_pos();
      r.query_gap  = rand_pos();
      r.location   = rand_pos();
      return r;
   endfunction

   // Query locations land mostly on the first, last and one-past-last
   // positions of a known block, or just before it; others fall within a block or anywhere.
   function automatic logic [POS_W-1:0] pick_location();
      int              k;
      longint unsigned loc;
      if (chain_starts.size() == 0 || $urandom_range(4) == 0) return rand_pos();
      k = $urandom_range(chain_starts.size() - 1);
      loc = 64'(chain_starts[k]);
      case ($urandom_range(4))
         0: loc = loc;
         1: loc = loc + 64'(chain_lengths[k]) - ((chain_lengths[k] != 0) ? 1 : 0);
         2: loc = loc + 64'(chain_lengths[k]);
         3: loc = (loc != 0) ? loc - 1 : loc;
         default: loc = loc + (64'($urandom) % (64'(chain_lengths[k]) + 1));
      endcase
      if (loc > 64'(POS_MAX)) loc = 64'(POS_MAX);
      return loc[POS_W-1:0];
   endfunction

   // Called at a falling edge. Idles at random outside the burst window,
   // presents the item, holds it until a rising edge finds busy low, and
   // returns at the next falling edge so the caller decides what start does.
   task automatic send(input req_type item);
      while ((items_sent < BURST_FIRST || items_sent >= BURST_LAST) &&
             $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
      if (item.mode != MODE_UNUSED) items_sent++;
   endtask

   // Drops start and waits until every outstanding result has come back.
   task automatic hold_until_drained();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic clear_chain();
      req_type r;
      r = rand_request();
      r.mode = MODE_CLEAR;
      chain_cursor = 0;
      chain_starts.delete();
      chain_lengths.delete();
      send(r);
   endtask

   task automatic append_block(input logic [POS_W-1:0] len, input logic [POS_W-1:0] tgap,
                               input logic [POS_W-1:0] qgap);
      req_type r;
      r = rand_request();
      r.mode       = MODE_APPEND;
      r.block_size = len;
      r.target_gap = tgap;
      r.query_gap  = qgap;
      // The sketch follows only the source side; a target overflow that the
      // block rejects just makes later locations a little less targeted.
      if (chain_starts.size() < TABLE_DEPTH &&
          chain_cursor + 64'(len) + 64'(qgap) <= 64'(POS_MAX)) begin
         chain_starts  = {chain_starts, chain_cursor[POS_W-1:0]};
         chain_lengths = {chain_lengths, len};
         chain_cursor = chain_cursor + 64'(len) + 64'(qgap);
      end
      send(r);
   endtask

   task automatic query_at(input logic [POS_W-1:0] loc);
      req_type r;
      r = rand_request();
      r.mode     = MODE_QUERY;
      r.location = loc;
      send(r);
   endtask

   // A run of stalled cycles with no transfer in either direction means the
   // block has hung or dropped a result.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[coordinate_liftover_block_table] ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_type noise;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      items_sent   = 0;
      chain_cursor = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Queries on the empty table come first, then the
      // unused mode with every field set.
      query_at('0);
      query_at(POS_MAX);
      noise = '1;
      send(noise);

      // A zero-length block, then two real blocks separated by a source gap.
      // The zero-length block shares its start with the next block, so the
      // search must settle on the later of the two.
      append_block('0, '0, '0);
      query_at('0);
      append_block(POS_W'(100), POS_W'(50), POS_W'(20));
      append_block(POS_W'(10), '0, '0);
      query_at('0);
      query_at(POS_W'(99));
      query_at(POS_W'(100));
      query_at(POS_W'(125));
      query_at(POS_W'(130));

      // After a clear the table must behave as empty again.
      clear_chain();
      query_at(POS_W'(5));

      // One block spanning the whole source range: the last coordinate lies
      // past its end, and any further length pushes the source past range.
      append_block(POS_MAX, '0, '0);
      query_at(POS_MAX - 1);
      query_at(POS_MAX);
      append_block(POS_W'(1), '0, '0);
      append_block('0, '0, '0);
      query_at(POS_MAX);

      // Target-side overflow on its own, then a source gap of the full range.
      clear_chain();
      append_block('0, POS_MAX, '0);
      append_block('0, POS_W'(1), '0);
      append_block('0, '0, POS_MAX);
      query_at('0);

      // Let the block empty out completely before the random part.
      hold_until_drained();

      // Random part: mostly whole chains built from a clear, with queries
      // woven in and a batch at the end. A few chains run past the table
      // depth to hit the full case. The rest is random noise of any mode.
      while (items_sent < RANDOM_ITEMS + 25) begin
         if ($urandom_range(7) == 0) hold_until_drained();
         if ($urandom_range(99) < 85) begin
            clear_chain();
            chain_blocks = ($urandom_range(14) == 0) ?
                           $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6) :
                           $urandom_range(1, 24);
            repeat (chain_blocks) begin
               append_block(rand_span(), rand_span(), rand_span());
               if ($urandom_range(3) == 0) query_at(pick_location());
            end
            repeat ($urandom_range(1, 16)) query_at(pick_location());
         end else begin
            repeat ($urandom_range(1, 4)) send(rand_request());
         end
      end

      // Drain, then allow a few cycles for any stray result to show up.
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[coordinate_liftover_block_table] OK");
      end else begin
         $display("[coordinate_liftover_block_table] ERROR");
      end
      $finish;
   end

endmodule
